>>> rtl/core/ltok_pkg.sv
// Shared types, token kind codes and keyword tables for the line tokenizer.
// No dependencies; all files that use it reference it by scoped names.
`default_nettype none
package ltok_pkg;

  // One result item
  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] start;
    logic [12:0] len;
    logic [3:0]  kwi;
    logic [2:0]  err;
  } res_t;

  // One queue entry: the results of one input item
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // Queue head as seen by the output side
  typedef struct packed {
    logic   valid;
    entry_t head;
  } qhead_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Token kinds
  localparam logic [5:0] K_ERR     = 6'd0;
  localparam logic [5:0] K_SHLEQ   = 6'd1;
  localparam logic [5:0] K_SHL     = 6'd2;
  localparam logic [5:0] K_LE      = 6'd3;
  localparam logic [5:0] K_NE      = 6'd4;
  localparam logic [5:0] K_LT      = 6'd5;
  localparam logic [5:0] K_SHREQ   = 6'd6;
  localparam logic [5:0] K_SHR     = 6'd7;
  localparam logic [5:0] K_GE      = 6'd8;
  localparam logic [5:0] K_GT      = 6'd9;
  localparam logic [5:0] K_INC     = 6'd10;
  localparam logic [5:0] K_ADDEQ   = 6'd11;
  localparam logic [5:0] K_ADD     = 6'd12;
  localparam logic [5:0] K_DEC_OP  = 6'd13;
  localparam logic [5:0] K_SUBEQ   = 6'd14;
  localparam logic [5:0] K_SUB     = 6'd15;
  localparam logic [5:0] K_OREQ    = 6'd16;
  localparam logic [5:0] K_OR      = 6'd17;
  localparam logic [5:0] K_ANDEQ   = 6'd18;
  localparam logic [5:0] K_AND     = 6'd19;
  localparam logic [5:0] K_EQEQ    = 6'd20;
  localparam logic [5:0] K_ASSIGN  = 6'd21;
  localparam logic [5:0] K_DEFINE  = 6'd22;
  localparam logic [5:0] K_COLON   = 6'd23;
  localparam logic [5:0] K_LBRACE  = 6'd24;
  localparam logic [5:0] K_BINARY  = 6'd32;
  localparam logic [5:0] K_HEXNUM  = 6'd33;
  localparam logic [5:0] K_FLOAT   = 6'd34;
  localparam logic [5:0] K_DECIMAL = 6'd35;
  localparam logic [5:0] K_KEYWORD = 6'd36;
  localparam logic [5:0] K_IDENT   = 6'd37;

  // Error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_EMPTYB  = 3'd1;
  localparam logic [2:0] E_EMPTYX  = 3'd2;
  localparam logic [2:0] E_NOFRAC  = 3'd3;
  localparam logic [2:0] E_UNKNOWN = 3'd4;
  localparam logic [2:0] E_TOOLONG = 3'd5;

  localparam logic [11:0] TOOLONG_COL = 12'd4095;

  // Keywords, first character in the top byte
  localparam int NKW = 9;
  localparam logic [47:0] KW_TEXT [NKW] = '{
    "return", "if    ", "else  ", "for   ", "loop  ",
    "break ", "not   ", "and   ", "or    "
  };
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd6, 3'd2, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2
  };
  localparam logic [8:0] ALL_KW = 9'h1FF;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Drop keywords that do not have character c at position pos
  function automatic logic [8:0] kw_filter(input logic [8:0] cand, input logic pos_ok,
                                           input logic [2:0] pos, input logic [7:0] c);
    logic [8:0] o;
    o = cand;
    for (int k = 0; k < NKW; k++) begin
      if (!pos_ok || pos >= KW_LEN[k] || KW_TEXT[k][47 - 8*pos -: 8] != c) begin
        o[k] = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic res_t mk(input logic [5:0] kind, input logic [11:0] start,
                              input logic [12:0] len, input logic [3:0] kwi,
                              input logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.kwi   = kwi;
    r.err   = err;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ltok_if.sv
// Channel interfaces for the line tokenizer: character input and token output.
// Depends on nothing.
`default_nettype none
interface ltok_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] ch;
  modport source (output valid, mode, ch, input ready);
  modport sink   (input valid, mode, ch, output ready);
endinterface

interface ltok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [11:0] start_column;
  logic [12:0] token_length;
  logic [3:0]  keyword_index;
  logic [2:0]  error_code;
  logic        last;
  modport source (output valid, kind, start_column, token_length, keyword_index,
                  error_code, last, input ready);
  modport sink   (input valid, kind, start_column, token_length, keyword_index,
                  error_code, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ltok_front.sv
// Lexer front end: accepts one character or end of line per cycle when space_ok,
// keeps pending token state, makes up to two results per request. Uses ltok_pkg.
`default_nettype none
module ltok_front #(
  parameter int CW  = 13,
  parameter int MAX = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_mode,
  input  wire logic [7:0]      in_ch,
  input  wire logic            space_ok,
  output logic                 push,
  output ltok_pkg::entry_t     push_entry
);

  localparam logic [4:0] PH_IDLE = 5'd0,  PH_LT = 5'd1,    PH_LTLT = 5'd2,
                         PH_GT = 5'd3,    PH_GTGT = 5'd4,  PH_PLUS = 5'd5,
                         PH_MINUS = 5'd6, PH_PIPE = 5'd7,  PH_AMP = 5'd8,
                         PH_EQ = 5'd9,    PH_COLON = 5'd10, PH_SINGLE = 5'd11,
                         PH_UNKNOWN = 5'd12, PH_ZERO = 5'd13, PH_ZERO_B = 5'd14,
                         PH_ZERO_X = 5'd15, PH_BIN = 5'd16, PH_HEX = 5'd17,
                         PH_DEC = 5'd18,  PH_FLOAT = 5'd19, PH_IDENT = 5'd20;

  logic [4:0]    phase_r, phase_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [5:0]    held_r, held_nxt;
  logic [8:0]    cand_r, cand_nxt;
  logic          frac_r, frac_nxt;

  logic [CW-1:0]    pos;
  logic             pos_ok;
  logic [11:0]      s12;
  logic [12:0]      len13;
  ltok_pkg::res_t   f0, f1, x0, r0, r1;
  logic [1:0]       fn, n;
  logic             xn;
  logic             x_ok, x_idle, x_inc;
  logic [4:0]       x_phase;
  logic             x_frac;
  logic [8:0]       x_cand;
  logic             kw_hit;
  logic [3:0]       kw_idx;
  logic             acc;

  assign acc    = in_valid && space_ok;
  assign pos    = col_r - start_r;
  assign pos_ok = pos < CW'(6);
  assign s12    = 12'(start_r);
  assign len13  = 13'(pos);

  // Pick the first surviving keyword of the right length
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = ltok_pkg::NKW - 1; k >= 0; k--) begin
      if (cand_r[k] && 13'(ltok_pkg::KW_LEN[k]) == len13) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  // Report the pending token
  always_comb begin
    f0 = '0;
    f1 = '0;
    fn = 2'd0;
    case (phase_r)
      PH_LT:      begin f0 = ltok_pkg::mk(ltok_pkg::K_LT, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_LTLT:    begin f0 = ltok_pkg::mk(ltok_pkg::K_SHL, s12, 13'd2, '0, '0); fn = 2'd1; end
      PH_GT:      begin f0 = ltok_pkg::mk(ltok_pkg::K_GT, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_GTGT:    begin f0 = ltok_pkg::mk(ltok_pkg::K_SHR, s12, 13'd2, '0, '0); fn = 2'd1; end
      PH_PLUS:    begin f0 = ltok_pkg::mk(ltok_pkg::K_ADD, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_MINUS:   begin f0 = ltok_pkg::mk(ltok_pkg::K_SUB, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_PIPE:    begin f0 = ltok_pkg::mk(ltok_pkg::K_OR, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_AMP:     begin f0 = ltok_pkg::mk(ltok_pkg::K_AND, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_EQ:      begin f0 = ltok_pkg::mk(ltok_pkg::K_ASSIGN, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_COLON:   begin f0 = ltok_pkg::mk(ltok_pkg::K_COLON, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_SINGLE:  begin f0 = ltok_pkg::mk(held_r, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_UNKNOWN: begin
        f0 = ltok_pkg::mk(ltok_pkg::K_ERR, s12, '0, '0, ltok_pkg::E_UNKNOWN); fn = 2'd1;
      end
      PH_ZERO:    begin f0 = ltok_pkg::mk(ltok_pkg::K_DECIMAL, s12, 13'd1, '0, '0); fn = 2'd1; end
      PH_ZERO_B, PH_ZERO_X: begin
        f0 = ltok_pkg::mk(ltok_pkg::K_ERR, s12, '0, '0,
                          (phase_r == PH_ZERO_B) ? ltok_pkg::E_EMPTYB : ltok_pkg::E_EMPTYX);
        f1 = ltok_pkg::mk(ltok_pkg::K_IDENT, 12'(start_r + CW'(1)), 13'd1, '0, '0);
        fn = 2'd2;
      end
      PH_BIN:     begin f0 = ltok_pkg::mk(ltok_pkg::K_BINARY, s12, len13, '0, '0); fn = 2'd1; end
      PH_HEX:     begin f0 = ltok_pkg::mk(ltok_pkg::K_HEXNUM, s12, len13, '0, '0); fn = 2'd1; end
      PH_DEC:     begin f0 = ltok_pkg::mk(ltok_pkg::K_DECIMAL, s12, len13, '0, '0); fn = 2'd1; end
      PH_FLOAT: begin
        if (frac_r) begin
          f0 = ltok_pkg::mk(ltok_pkg::K_ERR, s12, '0, '0, ltok_pkg::E_NOFRAC);
          f1 = ltok_pkg::mk(ltok_pkg::K_FLOAT, s12, len13, '0, '0);
          fn = 2'd2;
        end else begin
          f0 = ltok_pkg::mk(ltok_pkg::K_FLOAT, s12, len13, '0, '0);
          fn = 2'd1;
        end
      end
      PH_IDENT: begin
        f0 = kw_hit ? ltok_pkg::mk(ltok_pkg::K_KEYWORD, s12, len13, kw_idx, '0)
                    : ltok_pkg::mk(ltok_pkg::K_IDENT, s12, len13, '0, '0);
        fn = 2'd1;
      end
      default: ;
    endcase
  end

  // Try to extend the pending token with the incoming character
  always_comb begin
    x_ok    = 1'b0;
    x_idle  = 1'b0;
    x_inc   = 1'b0;
    x_phase = phase_r;
    x_frac  = frac_r;
    x_cand  = cand_r;
    xn      = 1'b0;
    x0      = '0;
    case (phase_r)
      PH_LT: begin
        if (in_ch == "<") begin
          x_ok = 1'b1; x_phase = PH_LTLT;
        end else if (in_ch == "=" || in_ch == ">") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk((in_ch == "=") ? ltok_pkg::K_LE : ltok_pkg::K_NE,
                            s12, 13'd2, '0, '0);
        end
      end
      PH_GT: begin
        if (in_ch == ">") begin
          x_ok = 1'b1; x_phase = PH_GTGT;
        end else if (in_ch == "=") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk(ltok_pkg::K_GE, s12, 13'd2, '0, '0);
        end
      end
      PH_LTLT, PH_GTGT: begin
        if (in_ch == "=") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk((phase_r == PH_LTLT) ? ltok_pkg::K_SHLEQ : ltok_pkg::K_SHREQ,
                            s12, 13'd3, '0, '0);
        end
      end
      PH_PLUS: begin
        if (in_ch == "+" || in_ch == "=") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk((in_ch == "+") ? ltok_pkg::K_INC : ltok_pkg::K_ADDEQ,
                            s12, 13'd2, '0, '0);
        end
      end
      PH_MINUS: begin
        if (in_ch == "-" || in_ch == "=") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk((in_ch == "-") ? ltok_pkg::K_DEC_OP : ltok_pkg::K_SUBEQ,
                            s12, 13'd2, '0, '0);
        end
      end
      PH_PIPE, PH_AMP, PH_EQ, PH_COLON: begin
        if (in_ch == "=") begin
          x_ok = 1'b1; x_idle = 1'b1; xn = 1'b1;
          x0 = ltok_pkg::mk((phase_r == PH_PIPE) ? ltok_pkg::K_OREQ :
                            (phase_r == PH_AMP)  ? ltok_pkg::K_ANDEQ :
                            (phase_r == PH_EQ)   ? ltok_pkg::K_EQEQ : ltok_pkg::K_DEFINE,
                            s12, 13'd2, '0, '0);
        end
      end
      PH_ZERO: begin
        if (in_ch == "b") begin
          x_ok = 1'b1; x_phase = PH_ZERO_B;
        end else if (in_ch == "x") begin
          x_ok = 1'b1; x_phase = PH_ZERO_X;
        end else if (ltok_pkg::is_digit(in_ch)) begin
          x_ok = 1'b1; x_phase = PH_DEC;
        end else if (in_ch == ".") begin
          x_ok = 1'b1; x_phase = PH_FLOAT; x_frac = 1'b1;
        end
      end
      PH_ZERO_B, PH_ZERO_X: begin
        if ((phase_r == PH_ZERO_B) ? (in_ch == "0" || in_ch == "1")
                                   : ltok_pkg::is_hex(in_ch)) begin
          x_ok = 1'b1;
          x_phase = (phase_r == PH_ZERO_B) ? PH_BIN : PH_HEX;
        end else if (ltok_pkg::is_alnum(in_ch)) begin
          // Empty prefix: report it and restart as an identifier at the letter
          x_ok = 1'b1; x_inc = 1'b1; xn = 1'b1; x_phase = PH_IDENT;
          x0 = ltok_pkg::mk(ltok_pkg::K_ERR, s12, '0, '0,
                            (phase_r == PH_ZERO_B) ? ltok_pkg::E_EMPTYB : ltok_pkg::E_EMPTYX);
          x_cand = ltok_pkg::kw_filter(
                     ltok_pkg::kw_filter(ltok_pkg::ALL_KW, 1'b1, 3'd0,
                                         (phase_r == PH_ZERO_B) ? 8'("b") : 8'("x")),
                     1'b1, 3'd1, in_ch);
        end
      end
      PH_BIN:  x_ok = (in_ch == "0" || in_ch == "1");
      PH_HEX:  x_ok = ltok_pkg::is_hex(in_ch);
      PH_DEC: begin
        if (ltok_pkg::is_digit(in_ch)) begin
          x_ok = 1'b1;
        end else if (in_ch == ".") begin
          x_ok = 1'b1; x_phase = PH_FLOAT; x_frac = 1'b1;
        end
      end
      PH_FLOAT: begin
        if (ltok_pkg::is_digit(in_ch)) begin
          x_ok = 1'b1; x_frac = 1'b0;
        end
      end
      PH_IDENT: begin
        if (ltok_pkg::is_alnum(in_ch)) begin
          x_ok = 1'b1;
          x_cand = ltok_pkg::kw_filter(cand_r, pos_ok, pos[2:0], in_ch);
        end
      end
      default: ;
    endcase
  end

  // Select results and next state
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    held_nxt  = held_r;
    cand_nxt  = cand_r;
    frac_nxt  = frac_r;
    r0 = f0;
    r1 = f1;
    n  = fn;
    if (in_mode) begin
      phase_nxt = PH_IDLE;
      frac_nxt  = 1'b0;
      held_nxt  = '0;
      col_nxt   = '0;
      start_nxt = '0;
      cand_nxt  = ltok_pkg::ALL_KW;
    end else if (col_r >= CW'(MAX)) begin
      r0 = ltok_pkg::mk(ltok_pkg::K_ERR, ltok_pkg::TOOLONG_COL, '0, '0, ltok_pkg::E_TOOLONG);
      r1 = '0;
      n  = 2'd1;
    end else begin
      col_nxt = col_r + CW'(1);
      if (x_ok) begin
        r0 = x0;
        r1 = '0;
        n  = {1'b0, xn};
        cand_nxt = x_cand;
        if (x_inc) begin
          start_nxt = start_r + CW'(1);
        end
        if (x_idle) begin
          phase_nxt = PH_IDLE;
          frac_nxt  = 1'b0;
          held_nxt  = '0;
        end else begin
          phase_nxt = x_phase;
          frac_nxt  = x_frac;
        end
      end else begin
        // Close the pending token and open a new one
        start_nxt = col_r;
        frac_nxt  = 1'b0;
        held_nxt  = '0;
        case (in_ch)
          "{": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE; end
          "}": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd1; end
          "(": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd2; end
          ")": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd3; end
          "[": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd4; end
          "]": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd5; end
          ";": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd6; end
          ",": begin phase_nxt = PH_SINGLE; held_nxt = ltok_pkg::K_LBRACE + 6'd7; end
          "<": phase_nxt = PH_LT;
          ">": phase_nxt = PH_GT;
          "+": phase_nxt = PH_PLUS;
          "-": phase_nxt = PH_MINUS;
          "|": phase_nxt = PH_PIPE;
          "&": phase_nxt = PH_AMP;
          "=": phase_nxt = PH_EQ;
          ":": phase_nxt = PH_COLON;
          "0": phase_nxt = PH_ZERO;
          default: begin
            if (ltok_pkg::is_digit(in_ch)) begin
              phase_nxt = PH_DEC;
            end else if (ltok_pkg::is_alpha(in_ch)) begin
              phase_nxt = PH_IDENT;
              cand_nxt  = ltok_pkg::kw_filter(ltok_pkg::ALL_KW, 1'b1, 3'd0, in_ch);
            end else if (ltok_pkg::is_space(in_ch)) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_UNKNOWN;
            end
          end
        endcase
      end
    end
  end

  assign push           = acc && (n != 2'd0);
  assign push_entry.two = n[1];
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;

  // Advance lexer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      col_r   <= '0;
      start_r <= '0;
      held_r  <= '0;
      cand_r  <= ltok_pkg::ALL_KW;
      frac_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
      cand_r  <= cand_nxt;
      frac_r  <= frac_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ltok_queue.sv
// Short queue of result groups between the lexer front end and the output side.
// Uses ltok_pkg types.
`default_nettype none
module ltok_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  ltok_pkg::entry_t      push_entry,
  input  wire logic             pop,
  output logic                  space_ok,
  output ltok_pkg::qhead_t      head
);

  ltok_pkg::entry_t             mem_r [ltok_pkg::QDEPTH];
  logic [ltok_pkg::QAW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [ltok_pkg::QAW:0]       cnt_r, cnt_nxt;

  assign space_ok   = cnt_r != (ltok_pkg::QAW+1)'(ltok_pkg::QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.head  = mem_r[rd_r];

  // Move pointers and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (ltok_pkg::QAW+1)'(push) - (ltok_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ltok_back.sv
// Output side: splits each queued group into single result requests and
// flags the last one. Uses ltok_pkg types and the output interface.
`default_nettype none
module ltok_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ltok_pkg::qhead_t   head,
  output logic               pop,
  ltok_out_if.source         out_bus
);

  logic            sel_r, sel_nxt;
  logic            fin;
  ltok_pkg::res_t  cur;

  assign cur  = sel_r ? head.head.r1 : head.head.r0;
  assign fin  = !head.head.two || sel_r;
  assign pop  = head.valid && out_bus.ready && fin;

  assign out_bus.valid         = head.valid;
  assign out_bus.kind          = cur.kind;
  assign out_bus.start_column  = cur.start;
  assign out_bus.token_length  = cur.len;
  assign out_bus.keyword_index = cur.kwi;
  assign out_bus.error_code    = cur.err;
  assign out_bus.last          = fin;

  // Step to the second result of a group, back to the first after it
  always_comb begin
    sel_nxt = sel_r;
    if (head.valid && out_bus.ready) begin
      sel_nxt = !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/line_tokenizer_unit.sv
// Top level of the line tokenizer: lexer front end, result queue, output side.
// Depends on ltok_pkg, ltok_if, ltok_front, ltok_queue, ltok_back.
//
//   channel   dir   payload                                             handshake
//   in_bus    in    mode, ch                                            valid/ready
//   out_bus   out   kind, start_column, token_length, keyword_index,    valid/ready
//                   error_code, last
//
// One request is accepted per cycle while the four-group queue has room.
// Each request leaves zero, one or two results; the output side sends one per cycle
// while out_bus.ready is high, so an item with two results goes out as two transfers.
// Results of an accepted request are stored in the queue and sent from its head.
// Reset is synchronous, active low; it returns the lexer to column 0 and empties
// the queue. A stalled output fills the queue and then drops in_bus.ready.
`default_nettype none
module line_tokenizer_unit #(
  parameter int MAX_LINE_LENGTH = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ltok_in_if.sink     in_bus,
  ltok_out_if.source  out_bus
);

  localparam int CW = $clog2(MAX_LINE_LENGTH + 1);

  logic               space_ok;
  logic               push;
  logic               pop;
  ltok_pkg::entry_t   push_entry;
  ltok_pkg::qhead_t   head;

  assign in_bus.ready = space_ok;

  ltok_front #(.CW(CW), .MAX(MAX_LINE_LENGTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_mode    (in_bus.mode),
    .in_ch      (in_bus.ch),
    .space_ok   (space_ok),
    .push       (push),
    .push_entry (push_entry)
  );

  ltok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .space_ok   (space_ok),
    .head       (head)
  );

  ltok_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire

>>> rtl/core/ltok_checker.sv
// Port-level checks for the line tokenizer, bound to line_tokenizer_unit.
// Depends on ltok_pkg, line_tokenizer_unit and its interfaces.
`default_nettype none
module ltok_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  kind,
  input wire logic [11:0] start_column,
  input wire logic [12:0] token_length,
  input wire logic [3:0]  keyword_index,
  input wire logic [2:0]  error_code
);

  // Hold a stalled result request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(token_length))
    else $error("stalled result changed");

  // Error-only results carry a code and no length
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == ltok_pkg::K_ERR |->
      token_length == 13'd0 && error_code != ltok_pkg::E_NONE)
    else $error("bad error result");

  // Token results carry no error code and a length
  a_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != ltok_pkg::K_ERR |->
      error_code == ltok_pkg::E_NONE && token_length != 13'd0)
    else $error("bad token result");

  // Keyword index only on keywords
  a_kw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != ltok_pkg::K_KEYWORD |-> keyword_index == 4'd0)
    else $error("stray keyword index");

  // Too-long errors point at the last column
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code == ltok_pkg::E_TOOLONG |-> start_column == ltok_pkg::TOOLONG_COL)
    else $error("bad line length error column");

endmodule

bind line_tokenizer_unit ltok_checker u_ltok_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .kind          (out_bus.kind),
  .start_column  (out_bus.start_column),
  .token_length  (out_bus.token_length),
  .keyword_index (out_bus.keyword_index),
  .error_code    (out_bus.error_code)
);
`default_nettype wire

>>> tb/line_tokenizer_unit_tb.sv
// Testbench for line_tokenizer_unit: drives characters and end-of-line requests,
// predicts tokens with a local lexer model and checks every result in order.
// Depends on ltok_pkg, ltok_if and the RTL of line_tokenizer_unit.
`timescale 1ns / 100ps
module line_tokenizer_unit_tb;

  typedef enum logic [4:0] {
    LX_IDLE, LX_LT, LX_LTLT, LX_GT, LX_GTGT, LX_PLUS, LX_MINUS, LX_PIPE,
    LX_AMP, LX_EQ, LX_COLON, LX_SINGLE, LX_UNKNOWN, LX_ZERO, LX_ZERO_B,
    LX_ZERO_X, LX_BIN, LX_HEX, LX_DEC, LX_FLOAT, LX_IDENT
  } lex_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] start;
    logic [12:0] len;
    logic [3:0]  kwi;
    logic [2:0]  err;
    logic        last;
  } token_t;

  typedef struct {
    logic       eol;
    logic [7:0] ch;
    int         n;      // -1: predicted only; else count of typed results
    token_t     t0;
    token_t     t1;
  } row_t;

  localparam int LINE_MAX = 4096;
  localparam logic [7:0] CHARS_OF_INTEREST [40] = '{
    "<", ">", "=", "+", "-", "|", "&", ":", "{", "}", "(", ")", "[", "]",
    ";", ",", "0", "1", "9", "b", "x", "a", "f", "F", ".", " ", "\t", "r",
    "e", "i", "o", "n", "l", "k", "t", "d", "s", "u", "Z", "#"
  };
  localparam string WORDS [12] = '{
    "return", "if", "else", "for", "loop", "break", "not", "and", "or",
    "orx", "iff", "foo"
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ltok_in_if  in_bus ();
  ltok_out_if out_bus ();

  line_tokenizer_unit dut (.clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus));

  always #10 clk = ~clk;

  // Lexer model state
  lex_t        lx_phase;
  int unsigned lx_col;
  int unsigned lx_start;
  logic [5:0]  lx_single;
  logic [8:0]  lx_cand;
  logic        lx_nofrac;

  token_t      token_q[$];
  token_t      step_tokens[$];
  int          mismatches = 0;
  bit          quiet_tail = 0;
  bit          long_hold = 0;

  function automatic token_t tok(int kind, int start, int len, int kwi, int err);
    token_t t;
    t.kind = 6'(kind); t.start = 12'(start); t.len = 13'(len);
    t.kwi = 4'(kwi); t.err = 3'(err); t.last = 1'b0;
    return t;
  endfunction

  function automatic bit digit_c(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit hex_c(logic [7:0] c);
    return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] kw_char(int k, int p);
    string w;
    w = WORDS[k];
    return (p < w.len()) ? w[p] : 8'h00;
  endfunction

  // Drop keyword candidates that disagree with c at position p
  function automatic void narrow_keywords(int unsigned p, logic [7:0] c);
    for (int k = 0; k < ltok_pkg::NKW; k++) begin
      if (p >= WORDS[k].len() || kw_char(k, p) != c) lx_cand[k] = 1'b0;
    end
  endfunction

  function automatic void push(int kind, int start, int len, int kwi, int err);
    if (step_tokens.size() < 2) step_tokens.push_back(tok(kind, start, len, kwi, err));
  endfunction

  function automatic void go_idle();
    lx_phase = LX_IDLE; lx_nofrac = 1'b0; lx_single = '0;
  endfunction

  // Emit the pending token
  task automatic close_pending();
    int unsigned s, n;
    int kwf;
    s = lx_start;
    n = lx_col - lx_start;
    kwf = -1;
    case (lx_phase)
      LX_LT:      push(ltok_pkg::K_LT, s, 1, 0, ltok_pkg::E_NONE);
      LX_LTLT:    push(ltok_pkg::K_SHL, s, 2, 0, ltok_pkg::E_NONE);
      LX_GT:      push(ltok_pkg::K_GT, s, 1, 0, ltok_pkg::E_NONE);
      LX_GTGT:    push(ltok_pkg::K_SHR, s, 2, 0, ltok_pkg::E_NONE);
      LX_PLUS:    push(ltok_pkg::K_ADD, s, 1, 0, ltok_pkg::E_NONE);
      LX_MINUS:   push(ltok_pkg::K_SUB, s, 1, 0, ltok_pkg::E_NONE);
      LX_PIPE:    push(ltok_pkg::K_OR, s, 1, 0, ltok_pkg::E_NONE);
      LX_AMP:     push(ltok_pkg::K_AND, s, 1, 0, ltok_pkg::E_NONE);
      LX_EQ:      push(ltok_pkg::K_ASSIGN, s, 1, 0, ltok_pkg::E_NONE);
      LX_COLON:   push(ltok_pkg::K_COLON, s, 1, 0, ltok_pkg::E_NONE);
      LX_SINGLE:  push(lx_single, s, 1, 0, ltok_pkg::E_NONE);
      LX_UNKNOWN: push(ltok_pkg::K_ERR, s, 0, 0, ltok_pkg::E_UNKNOWN);
      LX_ZERO:    push(ltok_pkg::K_DECIMAL, s, 1, 0, ltok_pkg::E_NONE);
      LX_ZERO_B: begin
        push(ltok_pkg::K_ERR, s, 0, 0, ltok_pkg::E_EMPTYB);
        push(ltok_pkg::K_IDENT, s + 1, 1, 0, ltok_pkg::E_NONE);
      end
      LX_ZERO_X: begin
        push(ltok_pkg::K_ERR, s, 0, 0, ltok_pkg::E_EMPTYX);
        push(ltok_pkg::K_IDENT, s + 1, 1, 0, ltok_pkg::E_NONE);
      end
      LX_BIN:     push(ltok_pkg::K_BINARY, s, n, 0, ltok_pkg::E_NONE);
      LX_HEX:     push(ltok_pkg::K_HEXNUM, s, n, 0, ltok_pkg::E_NONE);
      LX_DEC:     push(ltok_pkg::K_DECIMAL, s, n, 0, ltok_pkg::E_NONE);
      LX_FLOAT: begin
        if (lx_nofrac) push(ltok_pkg::K_ERR, s, 0, 0, ltok_pkg::E_NOFRAC);
        push(ltok_pkg::K_FLOAT, s, n, 0, ltok_pkg::E_NONE);
      end
      LX_IDENT: begin
        for (int k = 0; k < ltok_pkg::NKW; k++) begin
          if (kwf < 0 && lx_cand[k] && WORDS[k].len() == n) kwf = k;
        end
        if (kwf >= 0) push(ltok_pkg::K_KEYWORD, s, n, kwf, ltok_pkg::E_NONE);
        else push(ltok_pkg::K_IDENT, s, n, 0, ltok_pkg::E_NONE);
      end
      default: ;
    endcase
    go_idle();
  endtask

  function automatic bit close_op(int kind, int len);
    push(kind, lx_start, len, 0, ltok_pkg::E_NONE);
    go_idle();
    return 1;
  endfunction

  // Try to grow the pending token by c
  function automatic bit grow(logic [7:0] c);
    bit bin;
    case (lx_phase)
      LX_LT: begin
        if (c == "<") begin lx_phase = LX_LTLT; return 1; end
        if (c == "=") return close_op(ltok_pkg::K_LE, 2);
        if (c == ">") return close_op(ltok_pkg::K_NE, 2);
        return 0;
      end
      LX_LTLT: return c == "=" ? close_op(ltok_pkg::K_SHLEQ, 3) : 0;
      LX_GT: begin
        if (c == ">") begin lx_phase = LX_GTGT; return 1; end
        if (c == "=") return close_op(ltok_pkg::K_GE, 2);
        return 0;
      end
      LX_GTGT: return c == "=" ? close_op(ltok_pkg::K_SHREQ, 3) : 0;
      LX_PLUS: begin
        if (c == "+") return close_op(ltok_pkg::K_INC, 2);
        return c == "=" ? close_op(ltok_pkg::K_ADDEQ, 2) : 0;
      end
      LX_MINUS: begin
        if (c == "-") return close_op(ltok_pkg::K_DEC_OP, 2);
        return c == "=" ? close_op(ltok_pkg::K_SUBEQ, 2) : 0;
      end
      LX_PIPE:  return c == "=" ? close_op(ltok_pkg::K_OREQ, 2) : 0;
      LX_AMP:   return c == "=" ? close_op(ltok_pkg::K_ANDEQ, 2) : 0;
      LX_EQ:    return c == "=" ? close_op(ltok_pkg::K_EQEQ, 2) : 0;
      LX_COLON: return c == "=" ? close_op(ltok_pkg::K_DEFINE, 2) : 0;
      LX_ZERO: begin
        if (c == "b") begin lx_phase = LX_ZERO_B; return 1; end
        if (c == "x") begin lx_phase = LX_ZERO_X; return 1; end
        if (digit_c(c)) begin lx_phase = LX_DEC; return 1; end
        if (c == ".") begin lx_phase = LX_FLOAT; lx_nofrac = 1'b1; return 1; end
        return 0;
      end
      LX_ZERO_B, LX_ZERO_X: begin
        bin = lx_phase == LX_ZERO_B;
        if (bin ? (c == "0" || c == "1") : hex_c(c)) begin
          lx_phase = bin ? LX_BIN : LX_HEX;
          return 1;
        end
        if (!(digit_c(c) || alpha_c(c))) return 0;
        push(ltok_pkg::K_ERR, lx_start, 0, 0, bin ? ltok_pkg::E_EMPTYB : ltok_pkg::E_EMPTYX);
        lx_start++;
        lx_cand = ltok_pkg::ALL_KW;
        narrow_keywords(0, bin ? "b" : "x");
        narrow_keywords(1, c);
        lx_phase = LX_IDENT;
        return 1;
      end
      LX_BIN: return c == "0" || c == "1";
      LX_HEX: return hex_c(c);
      LX_DEC: begin
        if (digit_c(c)) return 1;
        if (c == ".") begin lx_phase = LX_FLOAT; lx_nofrac = 1'b1; return 1; end
        return 0;
      end
      LX_FLOAT: begin
        if (digit_c(c)) begin lx_nofrac = 1'b0; return 1; end
        return 0;
      end
      LX_IDENT: begin
        if (!(digit_c(c) || alpha_c(c))) return 0;
        narrow_keywords(lx_col - lx_start, c);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic open_token(logic [7:0] c);
    lx_start = lx_col; lx_nofrac = 1'b0; lx_single = '0;
    case (c)
      "{": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE; end
      "}": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd1; end
      "(": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd2; end
      ")": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd3; end
      "[": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd4; end
      "]": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd5; end
      ";": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd6; end
      ",": begin lx_phase = LX_SINGLE; lx_single = ltok_pkg::K_LBRACE + 6'd7; end
      "<": lx_phase = LX_LT;
      ">": lx_phase = LX_GT;
      "+": lx_phase = LX_PLUS;
      "-": lx_phase = LX_MINUS;
      "|": lx_phase = LX_PIPE;
      "&": lx_phase = LX_AMP;
      "=": lx_phase = LX_EQ;
      ":": lx_phase = LX_COLON;
      "0": lx_phase = LX_ZERO;
      default: begin
        if (digit_c(c)) lx_phase = LX_DEC;
        else if (alpha_c(c)) begin
          lx_phase = LX_IDENT; lx_cand = ltok_pkg::ALL_KW; narrow_keywords(0, c);
        end else if (c == " " || (c >= 9 && c <= 13)) lx_phase = LX_IDLE;
        else lx_phase = LX_UNKNOWN;
      end
    endcase
  endtask

  task automatic lexer_reset();
    go_idle(); lx_col = 0; lx_start = 0; lx_cand = ltok_pkg::ALL_KW;
  endtask

  // Advance the lexer model by one request; leaves results in step_tokens
  task automatic lex_step(logic eol, logic [7:0] c);
    step_tokens.delete();
    if (eol) begin
      close_pending();
      lx_col = 0; lx_start = 0; lx_cand = ltok_pkg::ALL_KW;
    end else if (lx_col >= LINE_MAX) begin
      push(ltok_pkg::K_ERR, ltok_pkg::TOOLONG_COL, 0, 0, ltok_pkg::E_TOOLONG);
    end else begin
      if (!grow(c)) begin
        close_pending();
        open_token(c);
      end
      lx_col++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endtask

  // Drive one request and log its predicted tokens on acceptance
  task automatic send(logic eol, logic [7:0] c, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= eol;
    in_bus.ch    <= c;
    do @(posedge clk); while (!in_bus.ready);
    lex_step(eol, c);
    foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
  endtask

  task automatic send_word(string w, bit gaps);
    for (int i = 0; i < w.len(); i++) send(1'b0, w[i], gaps);
  endtask

  task automatic report(string what, token_t exp_t, token_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch %s: expected kind=%0d col=%0d len=%0d kw=%0d err=%0d ",
                "last=%0d, got kind=%0d col=%0d len=%0d kw=%0d err=%0d last=%0d"},
               $realtime, what, exp_t.kind, exp_t.start, exp_t.len, exp_t.kwi, exp_t.err,
               exp_t.last, got.kind, got.start, got.len, got.kwi, got.err, got.last);
  endtask

  // Compare each accepted token against the oldest prediction
  always @(posedge clk) begin
    token_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.kind, out_bus.start_column, out_bus.token_length,
             out_bus.keyword_index, out_bus.error_code, out_bus.last};
      if (token_q.size() == 0) report("unexpected token", '0, got);
      else begin
        want = token_q.pop_front();
        if (got !== want) report("token", want, got);
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none at the tail
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    row_t r;
    int pick, tail_cycles;
    in_bus.valid = 1'b0;
    in_bus.mode  = 1'b0;
    in_bus.ch    = 8'h00;
    lexer_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows for obvious results, others predicted
    r.eol = 1'b1; r.ch = 8'h00; r.n = 0; rows.push_back(r);          // eol, nothing pending
    r.eol = 1'b0; r.ch = "#"; r.n = 0; rows.push_back(r);            // unknown held
    r.eol = 1'b0; r.ch = 8'hFF; r.n = 1;
    r.t0 = tok(ltok_pkg::K_ERR, 0, 0, 0, ltok_pkg::E_UNKNOWN); r.t0.last = 1'b1;
    rows.push_back(r);
    r.eol = 1'b0; r.ch = 8'h00; r.n = 1;
    r.t0 = tok(ltok_pkg::K_ERR, 1, 0, 0, ltok_pkg::E_UNKNOWN); r.t0.last = 1'b1;
    rows.push_back(r);
    r.eol = 1'b1; r.ch = 8'h00; r.n = 1;
    r.t0 = tok(ltok_pkg::K_ERR, 2, 0, 0, ltok_pkg::E_UNKNOWN); r.t0.last = 1'b1;
    rows.push_back(r);
    foreach (CHARS_OF_INTEREST[i]) begin
      if (i < 18) begin
        r.eol = 1'b0; r.ch = CHARS_OF_INTEREST[i]; r.n = -1; rows.push_back(r);
      end
    end
    r.eol = 1'b1; r.ch = 8'h00; r.n = -1; rows.push_back(r);
    foreach (rows[i]) begin
      send(rows[i].eol, rows[i].ch, 0);
      if (rows[i].n >= 1 && step_tokens.size() >= 1 && step_tokens[0] !== rows[i].t0)
        report("directed", rows[i].t0, step_tokens[0]);
      if (rows[i].n >= 0 && step_tokens.size() != rows[i].n)
        report("directed count", rows[i].t0, '0);
    end

    // Keywords, operator and number forms, empty prefixes, missing fraction
    foreach (WORDS[i]) begin send_word(WORDS[i], 0); send(1'b0, " ", 0); end
    send_word("<<= >>= <> <= >= ++ += -- -= |= &= == := 0b 0x 0bz 0xq 12. 3.5 0b101 0xfA 07", 0);
    send(1'b1, 8'h00, 0);

    // Pressure: hold the receiver while requests keep coming
    long_hold = 1;
    send_word("a+b-c;d,e(f)[g]{h}", 1);
    send(1'b1, 8'h00, 1);

    // Random lines built mostly from tokens, some noise
    for (int i = 0; i < 360; i++) begin
      if (i == 300) quiet_tail = 1;
      pick = $urandom_range(0, 9);
      if (pick < 3) send_word(WORDS[$urandom_range(0, 11)], !quiet_tail);
      else if (pick < 8)
        send(1'b0, CHARS_OF_INTEREST[$urandom_range(0, 39)], !quiet_tail);
      else if (pick == 8) send(1'b0, 8'($urandom_range(0, 255)), !quiet_tail);
      else send(1'b1, 8'($urandom_range(0, 255)), !quiet_tail);
    end
    send(1'b1, 8'h00, 0);
    in_bus.valid <= 1'b0;
    quiet_tail = 1;

    tail_cycles = 0;
    while (token_q.size() != 0 && tail_cycles < 2000) begin
      @(posedge clk); tail_cycles++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
